/* design/sfq_pkg.sv */
// Package for the counting semaphore with a FIFO wait queue.
// Holds status codes, sequencer states and default parameter values.
// No dependencies.
`default_nettype none

package sfq_pkg;

  localparam int QueueDepthDef = 16;
  localparam int TaskIdBitsDef = 8;

  localparam int TaskW   = 8;
  localparam int StatusW = 3;
  localparam int CountW  = 8;

  localparam logic [StatusW-1:0] STAT_ACQUIRED   = 3'd0;
  localparam logic [StatusW-1:0] STAT_ALREADY    = 3'd1;
  localparam logic [StatusW-1:0] STAT_BLOCKED    = 3'd2;
  localparam logic [StatusW-1:0] STAT_COUNT_UP   = 3'd3;
  localparam logic [StatusW-1:0] STAT_HANDED     = 3'd4;
  localparam logic [StatusW-1:0] STAT_NOT_HOLDER = 3'd5;
  localparam logic [StatusW-1:0] STAT_FULL       = 3'd6;

  localparam logic ACT_DOWN = 1'b0;
  localparam logic ACT_UP   = 1'b1;

  localparam logic [CountW-1:0] COUNT_MAX   = 8'hFF;
  localparam logic [CountW-1:0] COUNT_RESET = 8'd1;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_EXEC
  } seq_state_t;

endpackage

`default_nettype wire

/* design/semaphore_fifo_wait_queue_top.sv */
// Top level of the counting semaphore with one recorded holder and a FIFO wait queue.
// Depends on sfq_pkg for status codes, sequencer states and parameter defaults.
//
// Usage:
//   Input channel: drive in_action (0 down, 1 up) and in_task_id with start high.
//   The item is taken at a rising edge where start is high and busy is low.
//   Result channel: out_valid is high for exactly one cycle with out_status,
//   out_woken_task, out_holder_valid, out_holder_after and out_count_after.
//   The receiver cannot stall; every result must be taken in its cycle.
//   Result timing: the item is registered at the accepting edge, the result is
//   computed in the execute cycle and registered onto the ports at its end.
//   A new item is not taken while busy is high. The wait queue sits in a
//   synchronous memory; the head entry is read in the accept cycle and the
//   read-modify-write of all state completes in the following execute cycle.
//   busy is high during the execute cycle, which keeps queue accesses apart.
//   Configuration: cfg_wr_en with cfg_wr_data writes initial_count; the count
//   itself is loaded too when no task holds and the queue is empty.
//   Reset (rst_n low, synchronous): count and initial_count become 1, holder
//   and queue pointers clear. The queue memory is not cleared.
`default_nettype none

module semaphore_fifo_wait_queue_top
  import sfq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QueueDepthDef,
  parameter int TASK_ID_BITS = TaskIdBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_action,
  input  wire logic [TaskW-1:0]   in_task_id,
  output logic                    out_valid,
  output logic [StatusW-1:0]      out_status,
  output logic [TaskW-1:0]        out_woken_task,
  output logic                    out_holder_valid,
  output logic [TaskW-1:0]        out_holder_after,
  output logic [CountW-1:0]       out_count_after,
  input  wire logic               cfg_wr_en,
  input  wire logic [CountW-1:0]  cfg_wr_data
);

  localparam int IdW   = (TASK_ID_BITS < TaskW) ? TASK_ID_BITS : TaskW;
  localparam int PtrW  = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FillW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FillMax = FillW'(QUEUE_DEPTH);

  seq_state_t state_r, state_nxt;

  logic               accept;
  logic               action_r;
  logic [IdW-1:0]     task_r;

  logic [CountW-1:0]  init_count_r, init_count_nxt;
  logic [CountW-1:0]  sem_count_r, sem_count_nxt;
  logic [IdW-1:0]     holder_id_r, holder_id_nxt;
  logic               holder_present_r, holder_present_nxt;
  logic [PtrW-1:0]    head_r, head_nxt;
  logic [PtrW-1:0]    tail_r, tail_nxt;
  logic [FillW-1:0]   fill_r, fill_nxt;

  logic [IdW-1:0]     queue_mem [QUEUE_DEPTH];
  logic [IdW-1:0]     head_data_r;
  logic               push;

  logic               is_holder;
  logic [StatusW-1:0] status;
  logic [IdW-1:0]     woken;
  logic               exec;

  logic               out_valid_r;
  logic [StatusW-1:0] out_status_r;
  logic [TaskW-1:0]   out_woken_r;
  logic               out_hvalid_r;
  logic [TaskW-1:0]   out_holder_r;
  logic [CountW-1:0]  out_count_r;

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: if (accept) state_nxt = SEQ_EXEC;
      SEQ_EXEC: state_nxt = SEQ_IDLE;
      default:  state_nxt = SEQ_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    case (state_r)
      SEQ_IDLE: busy = 1'b0;
      SEQ_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default:  busy = 1'b0;
    endcase
  end

  assign accept = start & ~busy;

  // Queue memory: head read every cycle, push in the execute cycle
  always_ff @(posedge clk) begin
    head_data_r <= queue_mem[head_r];
    if (push) begin
      queue_mem[tail_r] <= task_r;
    end
  end

  // Request decode and state update
  always_comb begin
    sem_count_nxt      = sem_count_r;
    holder_id_nxt      = holder_id_r;
    holder_present_nxt = holder_present_r;
    head_nxt           = head_r;
    tail_nxt           = tail_r;
    fill_nxt           = fill_r;
    init_count_nxt     = init_count_r;
    push               = 1'b0;
    woken              = '0;
    status             = STAT_NOT_HOLDER;
    is_holder          = holder_present_r && (task_r == holder_id_r);

    if (exec) begin
      if (action_r == ACT_DOWN) begin
        if (is_holder) begin
          status = STAT_ALREADY;
        end else if (sem_count_r != '0) begin
          sem_count_nxt      = sem_count_r - CountW'(1);
          holder_id_nxt      = task_r;
          holder_present_nxt = 1'b1;
          status             = STAT_ACQUIRED;
        end else if (fill_r >= FillMax) begin
          status = STAT_FULL;
        end else begin
          push     = 1'b1;
          tail_nxt = (tail_r == PtrLast) ? '0 : tail_r + PtrW'(1);
          fill_nxt = fill_r + FillW'(1);
          status   = STAT_BLOCKED;
        end
      end else begin
        if (!is_holder) begin
          status = STAT_NOT_HOLDER;
        end else if (fill_r == '0) begin
          if (sem_count_r == COUNT_MAX) begin
            status = STAT_FULL;
          end else begin
            sem_count_nxt = sem_count_r + CountW'(1);
            status        = STAT_COUNT_UP;
          end
          holder_present_nxt = 1'b0;
          holder_id_nxt      = '0;
        end else begin
          woken              = head_data_r;
          head_nxt           = (head_r == PtrLast) ? '0 : head_r + PtrW'(1);
          fill_nxt           = fill_r - FillW'(1);
          holder_id_nxt      = head_data_r;
          holder_present_nxt = 1'b1;
          status             = STAT_HANDED;
        end
      end
    end

    if (cfg_wr_en) begin
      init_count_nxt = cfg_wr_data;
      if (!holder_present_r && fill_r == '0) begin
        sem_count_nxt = cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= SEQ_IDLE;
      init_count_r     <= COUNT_RESET;
      sem_count_r      <= COUNT_RESET;
      holder_id_r      <= '0;
      holder_present_r <= 1'b0;
      head_r           <= '0;
      tail_r           <= '0;
      fill_r           <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      init_count_r     <= init_count_nxt;
      sem_count_r      <= sem_count_nxt;
      holder_id_r      <= holder_id_nxt;
      holder_present_r <= holder_present_nxt;
      head_r           <= head_nxt;
      tail_r           <= tail_nxt;
      fill_r           <= fill_nxt;
      out_valid_r      <= exec;
    end
  end

  // Latch the item and the result
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_action;
      task_r   <= in_task_id[IdW-1:0];
    end
    if (exec) begin
      out_status_r <= status;
      out_woken_r  <= TaskW'(woken);
      out_hvalid_r <= holder_present_nxt;
      out_holder_r <= holder_present_nxt ? TaskW'(holder_id_nxt) : '0;
      out_count_r  <= sem_count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_woken_task   = out_woken_r;
  assign out_holder_valid = out_hvalid_r;
  assign out_holder_after = out_holder_r;
  assign out_count_after  = out_count_r;

endmodule

`default_nettype wire
